>>> sv/cqt_pkg.sv
// Shared types and codes for the checkpoint quorum tally unit.
// Used by cqt_front, cqt_fifo, cqt_back and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cqt_pkg;

  localparam int SLOT_IDX_W = 6;
  localparam int RID_W      = 5;
  localparam logic [4:0] TALLY_MAX = 5'd31;

  localparam logic [1:0] FN_VOTE  = 2'd0;
  localparam logic [1:0] FN_AHEAD = 2'd1;
  localparam logic [1:0] FN_TRUNC = 2'd2;
  localparam logic [1:0] FN_QUERY = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD_REP = 3'd1;
  localparam logic [2:0] ST_BAD_LEN = 3'd2;
  localparam logic [2:0] ST_DUP     = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;
  localparam logic [2:0] ST_OLDER   = 3'd5;

  // Front sequencer steps.
  typedef enum logic [1:0] {
    FS_DIV_I,
    FS_DIV_S,
    FS_PUSH
  } cqt_fs_state_t;

  typedef struct packed {
    logic [1:0]            func;
    logic signed [31:0]    seqno;
    logic [RID_W-1:0]      rid;
    logic                  rep_ok;
    logic                  len_ok;
    logic [63:0]           digest;
    logic [SLOT_IDX_W-1:0] slot;
  } cqt_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_REPORT
  } cqt_bk_state_t;

endpackage
`default_nettype wire

>>> sv/cqt_fifo.sv
// Two-entry queue of classified items between the front and the back.
// Depends on cqt_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none
module cqt_fifo import cqt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire cqt_item_t push_item,
  output logic           pop_valid,
  input  wire logic      pop,
  output cqt_item_t      pop_item
);

  cqt_item_t  mem_r [2];
  logic [1:0] count_r, count_nxt;
  logic       wp_r, rp_r;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_item;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == 2'd2 |-> !do_push)
    else $error("queue written while full");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> count_r == $past(count_r) + 2'd1)
    else $error("queue count lost a push");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> wp_r == rp_r)
    else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

>>> sv/cqt_front.sv
// Front end: accepts beats, checks replica id and length, and maps the
// sequence number to a ring slot with two reciprocal multiplies.
// Depends on cqt_pkg; feeds cqt_fifo.
`timescale 1ns / 1ps
`default_nettype none
module cqt_front import cqt_pkg::*; #(
  parameter int SLOTS    = 4,
  parameter int INTERVAL = 128,
  parameter int REPLICAS = 16,
  parameter int MSG_MAX  = 256,
  parameter int MSG_MIN  = 48
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_func,
  input  wire logic signed [31:0] in_seqno,
  input  wire logic signed [5:0] in_replica,
  input  wire logic [63:0]       in_digest,
  input  wire logic [9:0]        in_msg_length,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output cqt_item_t              push_item
);

  // Exact quotient of a 31-bit value: floor(n * ceil(2^(31+l)/d) / 2^(31+l)).
  localparam int IL = $clog2(INTERVAL);
  localparam longint unsigned IM = ((64'd1 << (31 + IL)) + INTERVAL - 1) / INTERVAL;
  localparam int SL = $clog2(SLOTS);
  localparam longint unsigned SM = ((64'd1 << (31 + SL)) + SLOTS - 1) / SLOTS;

  logic              busy_r, busy_nxt;
  cqt_fs_state_t     step_r, step_nxt;
  logic [1:0]        func_r;
  logic signed [31:0] seqno_r;
  logic [5:0]        rep_r;
  logic [63:0]       digest_r;
  logic [9:0]        len_r;
  logic [30:0]       qi_r, qs_r;
  logic [62:0]       prod_i, prod_s;
  logic [30:0]       rem;
  logic              accept;

  always_comb begin
    push_valid = busy_r && (step_r == FS_PUSH);
    in_ready   = !busy_r || (push_valid && push_ready);
    accept     = in_valid && in_ready;
  end

  assign prod_i = 63'(seqno_r[30:0]) * 63'(IM[31:0]);
  assign prod_s = 63'(qi_r) * 63'(SM[31:0]);
  assign rem    = qi_r - 31'(qs_r * 31'(SLOTS));

  always_comb begin
    push_item.func   = func_r;
    push_item.seqno  = seqno_r;
    push_item.rid    = rep_r[RID_W-1:0];
    push_item.rep_ok = !rep_r[5] && ({1'b0, rep_r[4:0]} < 6'(REPLICAS));
    push_item.len_ok = (len_r >= 10'(MSG_MIN)) && (len_r <= 10'(MSG_MAX));
    push_item.digest = digest_r;
    // Negative sequence numbers land in slot zero.
    push_item.slot   = seqno_r[31] ? '0 : rem[SLOT_IDX_W-1:0];
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (accept) begin
      busy_nxt = 1'b1;
      step_nxt = FS_DIV_I;
    end else if (busy_r) begin
      unique case (step_r)
        FS_DIV_I: step_nxt = FS_DIV_S;
        FS_DIV_S: step_nxt = FS_PUSH;
        FS_PUSH: begin
          if (push_ready) begin
            busy_nxt = 1'b0;
          end
        end
        default: step_nxt = FS_DIV_I;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= FS_DIV_I;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r   <= in_func;
      seqno_r  <= in_seqno;
      rep_r    <= in_replica;
      digest_r <= in_digest;
      len_r    <= in_msg_length;
    end
    if (busy_r && step_r == FS_DIV_I) begin
      qi_r <= 31'(prod_i >> (31 + IL));
    end
    if (busy_r && step_r == FS_DIV_S) begin
      qs_r <= 31'(prod_s >> (31 + SL));
    end
  end

endmodule
`default_nettype wire

>>> sv/cqt_back.sv
// Back end: holds the slot ring, candidate tallies and above-window table,
// executes one queued item at a time and registers the result beat.
// Depends on cqt_pkg; fed by cqt_fifo.
`timescale 1ns / 1ps
`default_nettype none
module cqt_back import cqt_pkg::*; #(
  parameter int SLOTS      = 4,
  parameter int REPLICAS   = 16,
  parameter int CANDIDATES = 4
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      q_valid,
  input  wire cqt_item_t q_item,
  output logic           q_pop,
  input  wire logic [4:0] threshold,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic [2:0]     out_status,
  output logic           out_quorum_reached,
  output logic [4:0]     out_vote_count,
  output logic [63:0]    out_winning_digest
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RW = (REPLICAS > 1) ? $clog2(REPLICAS) : 1;
  localparam int CW = (CANDIDATES > 1) ? $clog2(CANDIDATES) : 1;
  localparam int UW = $clog2(CANDIDATES + 1);

  cqt_bk_state_t state_r, state_nxt;
  cqt_item_t     op_r;
  logic [2:0]    status_r, status_nxt;
  logic          exec_en, out_load, out_valid_r;

  logic signed [31:0]  slot_num_r  [SLOTS];
  logic [REPLICAS-1:0] mask_r      [SLOTS];
  logic [63:0]         cand_val_r  [SLOTS][CANDIDATES];
  logic [4:0]          cand_tly_r  [SLOTS][CANDIDATES];
  logic [UW-1:0]       used_r      [SLOTS];
  logic [4:0]          best_tly_r  [SLOTS];
  logic [63:0]         best_val_r  [SLOTS];
  logic signed [31:0]  ahead_num_r [REPLICAS];
  logic                ahead_vld_r [REPLICAS];

  logic [SW-1:0]       k;
  logic [RW-1:0]       rix;
  logic                match, dup, hit, full, bump, vote_go, ahead_go, ahead_old;
  logic [REPLICAS-1:0] mask_e;
  logic [UW-1:0]       used_e;
  logic [4:0]          best_e, old_t, new_t, rep_tly;
  logic [CW-1:0]       hit_idx, ci;
  logic                rep_q;

  assign k   = op_r.slot[SW-1:0];
  assign rix = op_r.rid[RW-1:0];

  // A slot holding another sequence number is seen as freshly cleared.
  always_comb begin
    match  = (slot_num_r[k] == $signed(op_r.seqno));
    mask_e = match ? mask_r[k] : '0;
    used_e = match ? used_r[k] : '0;
    best_e = match ? best_tly_r[k] : '0;
    dup    = mask_e[rix];
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = CANDIDATES - 1; i >= 0; i--) begin
      if ((UW'(i) < used_e) && (cand_val_r[k][i] == op_r.digest)) begin
        hit     = 1'b1;
        hit_idx = CW'(i);
      end
    end
    full  = !hit && (used_e >= UW'(CANDIDATES));
    ci    = hit ? hit_idx : used_e[CW-1:0];
    old_t = hit ? cand_tly_r[k][ci] : 5'd0;
    new_t = (old_t == TALLY_MAX) ? old_t : old_t + 5'd1;
    bump  = new_t > best_e;
    ahead_old = ahead_vld_r[rix] && ($signed(op_r.seqno) <= ahead_num_r[rix]);
  end

  always_comb begin
    vote_go    = 1'b0;
    ahead_go   = 1'b0;
    status_nxt = ST_OK;
    if (op_r.func == FN_VOTE || op_r.func == FN_AHEAD) begin
      priority if (!op_r.rep_ok) begin
        status_nxt = ST_BAD_REP;
      end else if (!op_r.len_ok) begin
        status_nxt = ST_BAD_LEN;
      end else if (op_r.func == FN_VOTE) begin
        vote_go = 1'b1;
        priority if (dup) begin
          status_nxt = ST_DUP;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_OK;
        end
      end else if (ahead_old) begin
        status_nxt = ST_OLDER;
      end else begin
        ahead_go = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:   if (q_valid) state_nxt = BK_EXEC;
      BK_EXEC:   state_nxt = BK_REPORT;
      BK_REPORT: if (!out_valid_r || out_ready) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state_r == BK_IDLE) && q_valid;
    exec_en  = (state_r == BK_EXEC);
    out_load = (state_r == BK_REPORT) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r <= q_item;
    end
    if (exec_en) begin
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) begin
        slot_num_r[s] <= '0;
        mask_r[s]     <= '0;
        used_r[s]     <= '0;
        best_tly_r[s] <= '0;
        best_val_r[s] <= '0;
        for (int c = 0; c < CANDIDATES; c++) begin
          cand_tly_r[s][c] <= '0;
        end
      end
      for (int r = 0; r < REPLICAS; r++) begin
        ahead_vld_r[r] <= 1'b0;
      end
    end else if (exec_en) begin
      if (vote_go) begin
        slot_num_r[k] <= op_r.seqno;
        mask_r[k]     <= mask_e | (REPLICAS'(1) << rix);
        if (!match) begin
          used_r[k]     <= '0;
          best_tly_r[k] <= '0;
          best_val_r[k] <= '0;
          for (int c = 0; c < CANDIDATES; c++) begin
            cand_tly_r[k][c] <= '0;
          end
        end
        if (!dup && !full) begin
          cand_tly_r[k][ci] <= new_t;
          used_r[k]         <= hit ? used_e : used_e + UW'(1);
          if (bump) begin
            best_tly_r[k] <= new_t;
            best_val_r[k] <= op_r.digest;
          end
        end
      end
      if (ahead_go) begin
        ahead_vld_r[rix] <= 1'b1;
      end
      if (op_r.func == FN_TRUNC) begin
        for (int s = 0; s < SLOTS; s++) begin
          if (slot_num_r[s] <= $signed(op_r.seqno)) begin
            slot_num_r[s] <= '0;
            mask_r[s]     <= '0;
            used_r[s]     <= '0;
            best_tly_r[s] <= '0;
            best_val_r[s] <= '0;
            for (int c = 0; c < CANDIDATES; c++) begin
              cand_tly_r[s][c] <= '0;
            end
          end
        end
        for (int r = 0; r < REPLICAS; r++) begin
          if (ahead_vld_r[r] && ahead_num_r[r] <= $signed(op_r.seqno)) begin
            ahead_vld_r[r] <= 1'b0;
          end
        end
      end
    end
  end

  // Digest and reported numbers are only read behind a used count or valid bit.
  always_ff @(posedge clk) begin
    if (exec_en && vote_go && !dup && !full) begin
      cand_val_r[k][ci] <= op_r.digest;
    end
    if (exec_en && ahead_go) begin
      ahead_num_r[rix] <= op_r.seqno;
    end
  end

  assign rep_tly = best_tly_r[k];
  assign rep_q   = rep_tly >= threshold;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status         <= status_r;
      out_quorum_reached <= rep_q;
      out_vote_count     <= rep_tly;
      out_winning_digest <= rep_q ? best_val_r[k] : 64'd0;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_exec_then_report: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_EXEC |=> state_r == BK_REPORT)
    else $error("execute step not followed by report");
  a_digest_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_quorum_reached |-> out_winning_digest == 64'd0)
    else $error("digest shown without quorum");
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_REPORT |-> used_r[k] <= UW'(CANDIDATES))
    else $error("candidate count beyond limit");
  a_load_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == BK_REPORT)
    else $error("result beat without an executed item");
`endif

endmodule
`default_nettype wire

>>> sv/checkpoint_quorum_tally_unit.sv
// Checkpoint quorum tally unit: front classifier, two-entry queue, back executor.
// Pace is set by the front's two registered reciprocal multiplies for the
// slot map and the back's three-step sequencer; the front takes a new beat
// only when idle or as it pushes the last one to the queue.
// Reset: synchronous active-low rst_n clears all tallies, slots and the
// above-window table at once; the quorum threshold returns to 3.
`timescale 1ns / 1ps
`default_nettype none
module checkpoint_quorum_tally_unit import cqt_pkg::*; #(
  parameter int SLOTS      = 4,
  parameter int INTERVAL   = 128,
  parameter int REPLICAS   = 16,
  parameter int CANDIDATES = 4,
  parameter int MSG_MAX    = 256,
  parameter int MSG_MIN    = 48
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [4:0]         cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_func,
  input  wire logic signed [31:0] in_seqno,
  input  wire logic signed [5:0]  in_replica,
  input  wire logic [63:0]        in_digest,
  input  wire logic [9:0]         in_msg_length,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_status,
  output logic                    out_quorum_reached,
  output logic [4:0]              out_vote_count,
  output logic [63:0]             out_winning_digest
);

  logic [4:0] threshold_r;
  logic       f_valid, f_ready, b_valid, b_pop;
  cqt_item_t  f_item, b_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= 5'd3;
    end else if (cfg_wr_en) begin
      threshold_r <= cfg_wr_data;
    end
  end

  cqt_front #(
    .SLOTS(SLOTS), .INTERVAL(INTERVAL), .REPLICAS(REPLICAS),
    .MSG_MAX(MSG_MAX), .MSG_MIN(MSG_MIN)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_func(in_func), .in_seqno(in_seqno), .in_replica(in_replica),
    .in_digest(in_digest), .in_msg_length(in_msg_length),
    .push_valid(f_valid), .push_ready(f_ready), .push_item(f_item)
  );

  cqt_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push_valid(f_valid), .push_ready(f_ready), .push_item(f_item),
    .pop_valid(b_valid), .pop(b_pop), .pop_item(b_item)
  );

  cqt_back #(
    .SLOTS(SLOTS), .REPLICAS(REPLICAS), .CANDIDATES(CANDIDATES)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(b_valid), .q_item(b_item), .q_pop(b_pop),
    .threshold(threshold_r),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_quorum_reached(out_quorum_reached),
    .out_vote_count(out_vote_count), .out_winning_digest(out_winning_digest)
  );

endmodule
`default_nettype wire
